### src/u8esc_pkg.sv
// ----------------------------------------------------------------------------
// u8esc_pkg
// Shared constants and byte helpers for the UTF-8 stray byte escaper:
// lead length decode, overlong check and expansion of escaped bytes.
// ----------------------------------------------------------------------------
package u8esc_pkg;

    localparam int unsigned RunDepth = 4;   // up to three held bytes plus the current one
    localparam int unsigned HeldDepth = 3;

    // escape of a zero byte: encoding of U+D800
    localparam logic [7:0] EscZero0 = 8'hED;
    localparam logic [7:0] EscZero1 = 8'hA0;
    localparam logic [7:0] EscZero2 = 8'h80;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] cnt_t;

    // sequence length minus one, taken from the lead byte
    function automatic cnt_t lead_extra(input byte_t b);
        cnt_t r;
        r = 2'd0;
        if (b[7:5] == 3'b110) begin
            r = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            r = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic logic is_overlong(input byte_t lead, input byte_t second);
        logic r;
        r = 1'b0;
        if (lead == 8'hC0 || lead == 8'hC1) begin
            r = 1'b1;
        end else if (lead == 8'hE0 && second < 8'hA0) begin
            r = 1'b1;
        end else if (lead == 8'hF0 && second < 8'h90) begin
            r = 1'b1;
        end
        return r;
    endfunction

    // index of the final output byte an item byte expands to
    function automatic cnt_t part_last(input byte_t b, input logic esc);
        cnt_t r;
        r = 2'd0;
        if (esc) begin
            if (b == 8'h00) begin
                r = 2'd2;
            end else if (b[7]) begin
                r = 2'd1;
            end
        end
        return r;
    endfunction

    function automatic byte_t part_byte(input byte_t b, input logic esc, input cnt_t sub);
        byte_t r;
        r = b;
        if (esc && b == 8'h00) begin
            case (sub)
                2'd0:    r = EscZero0;
                2'd1:    r = EscZero1;
                default: r = EscZero2;
            endcase
        end else if (esc && b[7]) begin
            if (sub == 2'd0) begin
                r = {6'b110000, b[7:6]};
            end else begin
                r = {2'b10, b[5:0]};
            end
        end
        return r;
    endfunction

endpackage

### src/utf8_stray_byte_escaper_unit.sv
// ----------------------------------------------------------------------------
// utf8_stray_byte_escaper_unit
// Passes a byte stream through, escaping bytes that do not form UTF-8.
// Throughput, while m_ready holds: one item per cycle while items give one byte
// each; an item that gives more than one byte holds the input until the single
// output byte register has drained the run register, one byte per cycle.
// Reset (aresetn, synchronous, active low) clears pending sequence and outputs.
// ----------------------------------------------------------------------------
module utf8_stray_byte_escaper_unit
    import u8esc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);

    // pending sequence
    byte_t held_reg [HeldDepth];
    byte_t held_next [HeldDepth];
    cnt_t  held_count_reg, held_count_next;
    cnt_t  expect_reg, expect_next;

    // run of item bytes waiting to be sent
    byte_t run_byte_reg [RunDepth];
    byte_t run_byte_next [RunDepth];
    logic  run_esc_reg, run_esc_next;
    cnt_t  run_last_reg, run_last_next;
    logic  run_valid_reg;
    logic  run_load;
    cnt_t  idx_reg, sub_reg;

    logic  m_valid_reg, m_last_reg;
    byte_t m_byte_reg;

    logic  s_fire, emit_fire, part_end, run_end;
    byte_t cur_byte, emit_byte;
    cnt_t  exp_dec;

    assign s_fire    = s_valid && s_ready;
    assign emit_fire = run_valid_reg && (!m_valid_reg || m_ready);
    assign cur_byte  = run_byte_reg[idx_reg];
    assign emit_byte = part_byte(cur_byte, run_esc_reg, sub_reg);
    assign part_end  = (sub_reg == part_last(cur_byte, run_esc_reg));
    assign run_end   = part_end && (idx_reg == run_last_reg);
    assign s_ready   = !run_valid_reg || (emit_fire && run_end);
    assign exp_dec   = expect_reg - 2'd1;

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_last_of_run = m_last_reg;

    always_comb begin
        for (int i = 0; i < HeldDepth; i++) begin
            held_next[i] = held_reg[i];
        end
        held_count_next = held_count_reg;
        expect_next     = expect_reg;
        run_load        = 1'b0;
        run_esc_next    = 1'b1;
        run_last_next   = held_count_reg;
        // held bytes first, the current byte right after them
        for (int i = 0; i < HeldDepth; i++) begin
            run_byte_next[i] = (cnt_t'(i) < held_count_reg) ? held_reg[i] : s_in_byte;
        end
        run_byte_next[RunDepth-1] = s_in_byte;

        if (expect_reg == 2'd0) begin
            if (!s_end_of_input) begin
                if (lead_extra(s_in_byte) == 2'd0) begin
                    run_load = 1'b1;
                end else begin
                    held_next[0]    = s_in_byte;
                    held_count_next = 2'd1;
                    expect_next     = lead_extra(s_in_byte);
                end
            end
        end else if (s_end_of_input) begin
            run_load        = 1'b1;
            run_last_next   = held_count_reg - 2'd1;
            held_count_next = 2'd0;
            expect_next     = 2'd0;
        end else if (s_in_byte[7:6] != 2'b10) begin
            run_load        = 1'b1;
            held_count_next = 2'd0;
            expect_next     = 2'd0;
        end else if (exp_dec != 2'd0) begin
            expect_next = exp_dec;
            if (held_count_reg != 2'd3) begin
                held_next[held_count_reg] = s_in_byte;
                held_count_next           = held_count_reg + 2'd1;
            end
        end else begin
            // sequence complete: raw unless overlong
            run_load        = 1'b1;
            run_esc_next    = is_overlong(held_reg[0],
                                  (held_count_reg >= 2'd2) ? held_reg[1] : s_in_byte);
            held_count_next = 2'd0;
            expect_next     = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 2'd0;
            expect_reg     <= 2'd0;
            run_valid_reg  <= 1'b0;
            idx_reg        <= 2'd0;
            sub_reg        <= 2'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                held_count_reg <= held_count_next;
                expect_reg     <= expect_next;
            end

            if (emit_fire) begin
                m_valid_reg <= 1'b1;
                if (run_end) begin
                    run_valid_reg <= 1'b0;
                    idx_reg       <= 2'd0;
                    sub_reg       <= 2'd0;
                end else if (part_end) begin
                    idx_reg <= idx_reg + 2'd1;
                    sub_reg <= 2'd0;
                end else begin
                    sub_reg <= sub_reg + 2'd1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (s_fire && run_load) begin
                run_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
                sub_reg       <= 2'd0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < HeldDepth; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
        if (s_fire && run_load) begin
            for (int i = 0; i < RunDepth; i++) begin
                run_byte_reg[i] <= run_byte_next[i];
            end
            run_esc_reg  <= run_esc_next;
            run_last_reg <= run_last_next;
        end
        if (emit_fire) begin
            m_byte_reg <= emit_byte;
            m_last_reg <= run_end;
        end
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 stray byte escaper. A short table of
// directed bytes is followed by random, mostly well-formed sequences with
// broken and overlong ones mixed in. Every accepted item runs through a local
// escaper model; each output byte is checked in order against it or typed bytes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import u8esc_pkg::*;

    typedef struct packed {
        byte_t out_byte;
        logic  last;
    } out_item_t;

    // directed row: bytes typed in are used in place of the model output
    typedef struct packed {
        byte_t       in_byte;
        logic        eoi;
        logic        typed;
        logic [1:0]  n_typed;
        logic [23:0] typed_bytes;
    } dir_row_t;

    typedef enum logic [2:0] {
        SEQ_ASCII, SEQ_TWO, SEQ_THREE, SEQ_FOUR,
        SEQ_OVERLONG, SEQ_CUT, SEQ_NOISE, SEQ_FLUSH
    } seq_kind_e;

    localparam int NumDirRows = 24;
    localparam int RandItems = 126;

    localparam dir_row_t DirRows [NumDirRows] = '{
        '{8'h00, 1'b0, 1'b1, 2'd3, 24'hEDA080},   // zero byte
        '{8'h7F, 1'b0, 1'b1, 2'd1, 24'h7F0000},
        '{8'hFF, 1'b0, 1'b1, 2'd2, 24'hC3BF00},   // invalid lead
        '{8'h80, 1'b0, 1'b1, 2'd2, 24'hC28000},   // stray trailing byte
        '{8'hA5, 1'b1, 1'b1, 2'd0, 24'h000000},   // flush with nothing held
        '{8'hC3, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'hA9, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'hE2, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h82, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'hAC, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'hC0, 1'b0, 1'b0, 2'd0, 24'h000000},   // overlong two byte form
        '{8'h80, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'hF0, 1'b0, 1'b0, 2'd0, 24'h000000},   // overlong four byte form
        '{8'h8F, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'hBF, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'hBF, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'hE2, 1'b0, 1'b0, 2'd0, 24'h000000},   // cut short by a flush
        '{8'h82, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'hFF, 1'b1, 1'b0, 2'd0, 24'h000000},
        '{8'hF0, 1'b0, 1'b0, 2'd0, 24'h000000},   // cut short by a zero byte
        '{8'h9F, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h98, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h00, 1'b0, 1'b0, 2'd0, 24'h000000},   // longest run
        '{8'hF8, 1'b0, 1'b1, 2'd2, 24'hC3B800}
    };

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    byte_t s_in_byte;
    logic  s_end_of_input;
    logic  m_valid;
    logic  m_ready;
    byte_t m_out_byte;
    logic  m_last_of_run;

    // model state of the pending sequence
    byte_t       pend_bytes [HeldDepth];
    int unsigned pend_cnt;
    int unsigned pend_need;

    byte_t       item_bytes [$];
    out_item_t   awaited_bytes [$];
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned max_idle;

    utf8_stray_byte_escaper_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_input(s_end_of_input),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    function automatic int unsigned seq_length(input byte_t b);
        int unsigned len;
        len = 1;
        if (b[7:5] == 3'b110) begin
            len = 2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3;
        end else if (b[7:3] == 5'b11110) begin
            len = 4;
        end
        return len;
    endfunction

    function automatic logic overlong_form(input byte_t lead, input byte_t second);
        return (lead == 8'hC0) || (lead == 8'hC1)
            || (lead == 8'hE0 && second < 8'hA0)
            || (lead == 8'hF0 && second < 8'h90);
    endfunction

    function automatic byte_t rand_trail();
        byte_t b;
        b = byte_t'($urandom_range(8'hBF, 8'h80));
        return b;
    endfunction

    // zero becomes U+D800, high bytes become U+0080..U+00FF
    task automatic add_escaped(input byte_t b);
        if (b == 8'h00) begin
            item_bytes.push_back(8'hED);
            item_bytes.push_back(8'hA0);
            item_bytes.push_back(8'h80);
        end else if (b[7]) begin
            item_bytes.push_back({6'b110000, b[7:6]});
            item_bytes.push_back({2'b10, b[5:0]});
        end else begin
            item_bytes.push_back(b);
        end
    endtask

    task automatic flush_pending();
        for (int i = 0; i < pend_cnt; i++) begin
            add_escaped(pend_bytes[i]);
        end
        pend_cnt = 0;
        pend_need = 0;
    endtask

    task automatic escape_predict(input byte_t b, input logic eoi);
        byte_t       second;
        int unsigned len;
        item_bytes.delete();
        if (pend_need == 0) begin
            if (!eoi) begin
                len = seq_length(b);
                if (len == 1) begin
                    add_escaped(b);
                end else begin
                    pend_bytes[0] = b;
                    pend_cnt = 1;
                    pend_need = len - 1;
                end
            end
        end else if (eoi) begin
            flush_pending();
        end else if (b[7:6] != 2'b10) begin
            flush_pending();
            add_escaped(b);
        end else begin
            pend_need--;
            if (pend_need != 0) begin
                if (pend_cnt < HeldDepth) begin
                    pend_bytes[pend_cnt] = b;
                    pend_cnt++;
                end
            end else begin
                second = (pend_cnt >= 2) ? pend_bytes[1] : b;
                if (overlong_form(pend_bytes[0], second)) begin
                    flush_pending();
                    add_escaped(b);
                end else begin
                    for (int i = 0; i < pend_cnt; i++) begin
                        item_bytes.push_back(pend_bytes[i]);
                    end
                    item_bytes.push_back(b);
                    pend_cnt = 0;
                end
            end
        end
    endtask

    // returns at the accepting edge with the expected bytes queued
    task automatic send_byte(input byte_t b, input logic eoi, input logic typed = 1'b0,
                             input logic [1:0] n_typed = 2'd0,
                             input logic [23:0] typed_bytes = 24'h0);
        int unsigned gap;
        gap = $urandom_range(0, max_idle);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        escape_predict(b, eoi);
        if (typed) begin
            item_bytes.delete();
            for (int i = 0; i < n_typed; i++) begin
                item_bytes.push_back(typed_bytes[23 - 8 * i -: 8]);
            end
        end
        foreach (item_bytes[i]) begin
            awaited_bytes.push_back('{item_bytes[i], i == item_bytes.size() - 1});
        end
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_bytes.size() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        byte_t       lead;
        byte_t       b;
        int unsigned pick;
        int unsigned len;
        int unsigned ntr;
        bit          paused;
        seq_kind_e   kind;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_end_of_input = 1'b0;
        m_ready = 1'b0;
        pend_cnt = 0;
        pend_need = 0;
        fail_count = 0;
        items_sent = 0;
        max_idle = 4;
        paused = 1'b0;
        for (int i = 0; i < HeldDepth; i++) begin
            pend_bytes[i] = 8'h00;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DirRows[i]) begin
            send_byte(DirRows[i].in_byte, DirRows[i].eoi, DirRows[i].typed,
                      DirRows[i].n_typed, DirRows[i].typed_bytes);
        end

        while (items_sent < NumDirRows + RandItems) begin
            // a stretch with no idling on either side
            max_idle = (items_sent >= NumDirRows + 90 && items_sent < NumDirRows + 120) ? 0 : 4;
            if (!paused && items_sent >= NumDirRows + 60) begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) kind = SEQ_ASCII;
            else if (pick < 32) kind = SEQ_TWO;
            else if (pick < 48) kind = SEQ_THREE;
            else if (pick < 64) kind = SEQ_FOUR;
            else if (pick < 76) kind = SEQ_OVERLONG;
            else if (pick < 88) kind = SEQ_CUT;
            else if (pick < 96) kind = SEQ_NOISE;
            else kind = SEQ_FLUSH;
            case (kind)
                SEQ_ASCII: begin
                    b = byte_t'($urandom_range(0, 127));
                    if ($urandom_range(0, 5) == 0) b = 8'h00;
                    send_byte(b, 1'b0);
                end
                SEQ_TWO: begin
                    lead = byte_t'($urandom_range(8'hDF, 8'hC2));
                    send_byte(lead, 1'b0);
                    send_byte(rand_trail(), 1'b0);
                end
                SEQ_THREE: begin
                    lead = byte_t'($urandom_range(8'hEF, 8'hE0));
                    if (lead == 8'hE0) b = byte_t'($urandom_range(8'hBF, 8'hA0));
                    else b = rand_trail();
                    send_byte(lead, 1'b0);
                    send_byte(b, 1'b0);
                    send_byte(rand_trail(), 1'b0);
                end
                SEQ_FOUR: begin
                    lead = byte_t'($urandom_range(8'hF7, 8'hF0));
                    if (lead == 8'hF0) b = byte_t'($urandom_range(8'hBF, 8'h90));
                    else b = rand_trail();
                    send_byte(lead, 1'b0);
                    send_byte(b, 1'b0);
                    send_byte(rand_trail(), 1'b0);
                    send_byte(rand_trail(), 1'b0);
                end
                SEQ_OVERLONG: begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0) begin
                        send_byte(byte_t'($urandom_range(8'hC1, 8'hC0)), 1'b0);
                        send_byte(rand_trail(), 1'b0);
                    end else if (pick == 1) begin
                        send_byte(8'hE0, 1'b0);
                        send_byte(byte_t'($urandom_range(8'h9F, 8'h80)), 1'b0);
                        send_byte(rand_trail(), 1'b0);
                    end else begin
                        send_byte(8'hF0, 1'b0);
                        send_byte(byte_t'($urandom_range(8'h8F, 8'h80)), 1'b0);
                        send_byte(rand_trail(), 1'b0);
                        send_byte(rand_trail(), 1'b0);
                    end
                end
                SEQ_CUT: begin
                    len = $urandom_range(2, 4);
                    if (len == 2) lead = byte_t'($urandom_range(8'hDF, 8'hC0));
                    else if (len == 3) lead = byte_t'($urandom_range(8'hEF, 8'hE0));
                    else lead = byte_t'($urandom_range(8'hF7, 8'hF0));
                    ntr = $urandom_range(0, len - 2);
                    send_byte(lead, 1'b0);
                    repeat (ntr) send_byte(rand_trail(), 1'b0);
                    b = byte_t'($urandom_range(0, 255));
                    if ($urandom_range(0, 2) == 0) begin
                        send_byte(b, 1'b1);
                    end else begin
                        // anything but a trailing byte breaks the sequence
                        if (b[7:6] == 2'b10) b[6] = 1'b1;
                        send_byte(b, 1'b0);
                    end
                end
                SEQ_NOISE: begin
                    send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
                end
                default: begin
                    send_byte(byte_t'($urandom_range(0, 255)), 1'b1);
                end
            endcase
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (awaited_bytes.size() != 0) begin
            note_failure($sformatf("%0d expected bytes never arrived", awaited_bytes.size()));
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned gap;
        out_item_t   want;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, max_idle);
            repeat (gap) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (awaited_bytes.size() == 0) begin
                note_failure($sformatf("unexpected item: byte %02h last %0b",
                                       m_out_byte, m_last_of_run));
            end else begin
                want = awaited_bytes.pop_front();
                if (m_out_byte !== want.out_byte || m_last_of_run !== want.last) begin
                    note_failure($sformatf("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                           want.out_byte, want.last, m_out_byte, m_last_of_run));
                end
            end
        end
    end

    initial begin : watchdog
        #200us;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### utf8_stray_byte_escaper_unit.f
src/u8esc_pkg.sv
src/utf8_stray_byte_escaper_unit.sv
dv/testbench.sv
